>>> rtl/b85dec_pkg.sv
// Shared types and constants for the btoa base-85 decoder.
// No dependencies; imported by the front end, back end, top level and bench.
`default_nettype none
package b85dec_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_CHAR   = 3'd1,
    ST_Z_IN_GROUP = 3'd2,
    ST_OVERFLOW   = 3'd3,
    ST_PARTIAL    = 3'd4,
    ST_LENGTH     = 3'd5,
    ST_PAD        = 3'd6,
    ST_CHECKSUM   = 3'd7
  } b85dec_status_t;

  typedef enum logic [1:0] {
    REG_DECL_SIZE = 2'd0,
    REG_EXP_XOR   = 2'd1,
    REG_EXP_SUM   = 2'd2,
    REG_EXP_ROT   = 2'd3
  } b85dec_reg_t;

  localparam int unsigned SIZE_W   = 25;
  localparam int unsigned RADIX    = 85;
  localparam int unsigned GROUP_LEN = 5;
  localparam int unsigned PAD_MAX  = 3;

  localparam logic [7:0] CH_FIRST = 8'h21;  // '!'
  localparam logic [7:0] CH_LAST  = 8'h75;  // 'u'
  localparam logic [7:0] CH_ZERO  = 8'h7A;  // 'z'
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Work handed from front to back: one decoded word or one end request.
  typedef struct packed {
    logic           is_end;
    logic [31:0]    word;
    b85dec_status_t status;
  } b85dec_job_t;

  typedef struct packed {
    logic [7:0]     data;
    logic           byte_valid;
    b85dec_status_t status;
    logic           last;
  } b85dec_res_t;

endpackage
`default_nettype wire

>>> rtl/b85dec_fifo.sv
// Small register FIFO with queue-style flags; used for the job queue
// and for the result queue. Depends on nothing.
`default_nettype none
module b85dec_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);
  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = PW + 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

>>> rtl/b85dec_front.sv
// Front end: accepts characters, builds base-85 groups, tracks errors and
// byte count, and queues word and end jobs. Depends on b85dec_pkg.
`default_nettype none
module b85dec_front
  import b85dec_pkg::*;
#(
  parameter int unsigned MAX_OUTPUT_BYTES = 16777216,
  parameter int unsigned CNT_W = 25
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic              mode,
  input  wire logic [7:0]        char_code,
  input  wire logic [SIZE_W-1:0] declared_size,
  output logic                   job_push,
  output b85dec_job_t            job
);
  localparam int unsigned CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

  logic [31:0]      gw_r, gw_nxt, gw_acc;
  logic [2:0]       dc_r, dc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  b85dec_status_t   err_r, err_nxt;
  logic [CMP_W-1:0] cnt_x, decl_x;
  logic             length_bad, at_limit;

  assign cnt_x    = CMP_W'(cnt_r);
  assign decl_x   = CMP_W'(declared_size);
  assign at_limit = (cnt_r >= CNT_W'(MAX_OUTPUT_BYTES));
  assign length_bad = (decl_x > CMP_W'(MAX_OUTPUT_BYTES)) || (decl_x > cnt_x) ||
                      ((cnt_x - decl_x) > CMP_W'(PAD_MAX));
  assign gw_acc = gw_r * 32'(RADIX) + {24'd0, char_code - CH_FIRST};

  always_comb begin
    gw_nxt     = gw_r;
    dc_nxt     = dc_r;
    cnt_nxt    = cnt_r;
    err_nxt    = err_r;
    job_push   = 1'b0;
    job.is_end = 1'b0;
    job.word   = '0;
    job.status = ST_OK;
    if (accept) begin
      if (mode) begin
        job_push   = 1'b1;
        job.is_end = 1'b1;
        if (err_r != ST_OK) begin
          job.status = err_r;
        end else if (dc_r != '0) begin
          job.status = ST_PARTIAL;
        end else if (length_bad) begin
          job.status = ST_LENGTH;
        end
      end else if (err_r != ST_OK) begin
        // sticky error: characters are dropped
      end else if (char_code inside {CH_TAB, CH_LF, CH_CR, CH_SPACE}) begin
        // whitespace
      end else if (char_code == CH_ZERO) begin
        if (dc_r != '0) begin
          err_nxt = ST_Z_IN_GROUP;
        end else if (at_limit) begin
          err_nxt = ST_OVERFLOW;
        end else begin
          job_push = 1'b1;
          cnt_nxt  = cnt_r + CNT_W'(4);
        end
      end else if (!(char_code inside {[CH_FIRST:CH_LAST]})) begin
        err_nxt = ST_BAD_CHAR;
      end else if (dc_r == 3'(GROUP_LEN - 1)) begin
        gw_nxt = '0;
        dc_nxt = '0;
        if (at_limit) begin
          err_nxt = ST_OVERFLOW;
        end else begin
          job_push = 1'b1;
          job.word = gw_acc;
          cnt_nxt  = cnt_r + CNT_W'(4);
        end
      end else begin
        gw_nxt = gw_acc;
        dc_nxt = dc_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r  <= '0;
      dc_r  <= '0;
      cnt_r <= '0;
      err_r <= ST_OK;
    end else begin
      gw_r  <= gw_nxt;
      dc_r  <= dc_nxt;
      cnt_r <= cnt_nxt;
      err_r <= err_nxt;
    end
  end

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ST_OK) |=> (err_r == $past(err_r)))
    else $error("front: error code changed after being latched");

  a_dc_range: assert property (@(posedge clk) disable iff (!rst_n)
    dc_r < 3'(GROUP_LEN))
    else $error("front: digit count out of range");

  a_no_job_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    (job_push && !job.is_end) |-> (err_r == ST_OK && dc_nxt == '0))
    else $error("front: word job issued while errored or mid-group");

endmodule
`default_nettype wire

>>> rtl/b85dec_back.sv
// Back end: splits queued words into bytes, keeps the checksums and pad
// flag, resolves end status and writes results. Depends on b85dec_pkg.
`default_nettype none
module b85dec_back
  import b85dec_pkg::*;
#(
  parameter int unsigned CNT_W = 25
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_empty,
  input  b85dec_job_t            job,
  output logic                   job_pop,
  input  wire logic [SIZE_W-1:0] declared_size,
  input  wire logic [31:0]       expected_xor,
  input  wire logic [31:0]       expected_sum,
  input  wire logic [31:0]       expected_rotsum,
  input  wire logic              res_full,
  output logic                   res_push,
  output b85dec_res_t            res
);
  localparam int unsigned CMP_W = ((CNT_W > SIZE_W) ? CNT_W : SIZE_W) + 1;

  logic [1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0] bcnt_r, bcnt_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [31:0]      sum_r, sum_nxt;
  logic [31:0]      rot_r, rot_nxt;
  logic             pad_r, pad_nxt;
  logic [7:0]       cur;
  logic             emit, stall, mismatch;
  logic [CMP_W-1:0] bcnt_x, decl_x;

  assign cur    = job.word[8*(3 - idx_r) +: 8];
  assign bcnt_x = CMP_W'(bcnt_r);
  assign decl_x = CMP_W'(declared_size);
  assign emit   = bcnt_x < decl_x;
  assign mismatch = ({24'd0, xor_r} != expected_xor) || (sum_r != expected_sum) ||
                    (rot_r != expected_rotsum);

  always_comb begin
    idx_nxt        = idx_r;
    bcnt_nxt       = bcnt_r;
    xor_nxt        = xor_r;
    sum_nxt        = sum_r;
    rot_nxt        = rot_r;
    pad_nxt        = pad_r;
    job_pop        = 1'b0;
    res_push       = 1'b0;
    res.data       = '0;
    res.byte_valid = 1'b0;
    res.status     = ST_OK;
    res.last       = 1'b1;
    stall          = 1'b0;
    if (!job_empty) begin
      if (job.is_end) begin
        stall = res_full;
        if (!res_full) begin
          res_push = 1'b1;
          job_pop  = 1'b1;
          if (job.status != ST_OK) begin
            res.status = job.status;
          end else if (pad_r) begin
            res.status = ST_PAD;
          end else if (mismatch) begin
            res.status = ST_CHECKSUM;
          end
        end
      end else begin
        stall = emit && res_full;
        if (!stall) begin
          res_push       = emit;
          res.data       = cur;
          res.byte_valid = 1'b1;
          res.last       = (idx_r == 2'd3) || ((bcnt_x + 1'b1) >= decl_x);
          xor_nxt  = xor_r ^ cur;
          sum_nxt  = sum_r + {24'd0, cur} + 32'd1;
          rot_nxt  = {rot_r[30:0], rot_r[31]} + {24'd0, cur};
          pad_nxt  = pad_r || (!emit && cur != 8'd0);
          bcnt_nxt = bcnt_r + 1'b1;
          idx_nxt  = idx_r + 2'd1;
          job_pop  = (idx_r == 2'd3);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      bcnt_r <= '0;
      xor_r  <= '0;
      sum_r  <= '0;
      rot_r  <= '0;
      pad_r  <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      bcnt_r <= bcnt_nxt;
      xor_r  <= xor_nxt;
      sum_r  <= sum_nxt;
      rot_r  <= rot_nxt;
      pad_r  <= pad_nxt;
    end
  end

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("back: result written into full queue");

  a_word_held: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 2'd0) |-> (!job_empty && !job.is_end))
    else $error("back: word left the queue before all bytes were taken");

  a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r[1:0] == idx_r)
    else $error("back: byte count out of step with word position");

endmodule
`default_nettype wire

>>> rtl/btoa_base85_decoder_top.sv
// btoa base-85 decoder top level: configuration registers, front end,
// job queue, back end and result queue. Depends on b85dec_pkg and all rtl.
//
// Usage:
//   Input channel (push/full, in_mode, in_char_code): one payload character
//   or an end request per beat. Result channel (empty/pop, out_byte,
//   out_byte_valid, out_status, out_last): data bytes and final status
//   results, oldest first. Configuration over the APB-style port: declared
//   size at 0x0, expected XOR at 0x4, sum at 0x8, rotate checksum at 0xC;
//   write them only while the block is idle.
// Throughput: one character per cycle while full is low. Each group or 'z'
//   holds the byte unit until its four bytes are split off, so a run of 'z'
//   fills the four-entry job queue and full rises until the unit catches up.
// Path: a beat's job is registered in the job queue and its results in the
//   result queue; a word's bytes follow one per cycle while that queue has room.
// Reset (rst_n low, synchronous): all queues empty, decoder state, error
//   code, checksums and registers cleared.
// A stalled receiver fills the result queue; the byte unit then holds,
//   the job queue fills and full is raised. No result is dropped.
`default_nettype none
module btoa_base85_decoder_top
  import b85dec_pkg::*;
#(
  parameter int unsigned MAX_OUTPUT_BYTES = 16777216
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic        in_mode,
  input  wire logic [7:0]  in_char_code,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic [2:0]       out_status,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int unsigned CNT_W = $clog2(MAX_OUTPUT_BYTES + 4);
  localparam int unsigned JOB_W = $bits(b85dec_job_t);
  localparam int unsigned RES_W = $bits(b85dec_res_t);

  logic [SIZE_W-1:0] decl_r;
  logic [31:0]       exp_xor_r, exp_sum_r, exp_rot_r;
  b85dec_reg_t       reg_sel;
  logic              cfg_wr, accept;
  logic              job_push, job_full, job_empty, job_pop;
  b85dec_job_t       job_in, job_out;
  logic              res_push, res_full;
  b85dec_res_t       res_in, res_out;

  assign pready  = 1'b1;
  assign reg_sel = b85dec_reg_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_sel)
      REG_DECL_SIZE: prdata = 32'(decl_r);
      REG_EXP_XOR:   prdata = exp_xor_r;
      REG_EXP_SUM:   prdata = exp_sum_r;
      REG_EXP_ROT:   prdata = exp_rot_r;
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decl_r    <= '0;
      exp_xor_r <= '0;
      exp_sum_r <= '0;
      exp_rot_r <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_DECL_SIZE: decl_r    <= pwdata[SIZE_W-1:0];
        REG_EXP_XOR:   exp_xor_r <= pwdata;
        REG_EXP_SUM:   exp_sum_r <= pwdata;
        REG_EXP_ROT:   exp_rot_r <= pwdata;
        default:       ;
      endcase
    end
  end

  assign full   = job_full;
  assign accept = push && !job_full;

  b85dec_front #(
    .MAX_OUTPUT_BYTES(MAX_OUTPUT_BYTES),
    .CNT_W           (CNT_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .mode         (in_mode),
    .char_code    (in_char_code),
    .declared_size(decl_r),
    .job_push     (job_push),
    .job          (job_in)
  );

  b85dec_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(4)
  ) u_job_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (job_push),
    .wdata(job_in),
    .full (job_full),
    .pop  (job_pop),
    .rdata(job_out),
    .empty(job_empty)
  );

  b85dec_back #(
    .CNT_W(CNT_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_empty      (job_empty),
    .job            (job_out),
    .job_pop        (job_pop),
    .declared_size  (decl_r),
    .expected_xor   (exp_xor_r),
    .expected_sum   (exp_sum_r),
    .expected_rotsum(exp_rot_r),
    .res_full       (res_full),
    .res_push       (res_push),
    .res            (res_in)
  );

  b85dec_fifo #(
    .WIDTH(RES_W),
    .DEPTH(4)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res_in),
    .full (res_full),
    .pop  (pop),
    .rdata(res_out),
    .empty(empty)
  );

  assign out_byte       = res_out.data;
  assign out_byte_valid = res_out.byte_valid;
  assign out_status     = res_out.status;
  assign out_last       = res_out.last;

endmodule
`default_nettype wire

>>> tb/sv/tb_btoa_base85_decoder_top.sv
`timescale 1ns / 100ps
// Self-checking bench for btoa_base85_decoder_top: a directed table, then random
// character streams, every result beat checked against an in-bench decoder model
// or the table's status for typed rows. Depends on b85dec_pkg and the block's rtl.
module tb_btoa_base85_decoder_top;
  import b85dec_pkg::*;

  localparam int unsigned MAX_BYTES    = 384;
  localparam int unsigned CLK_HALF     = 10;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned RANDOM_ITEMS = 150;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned HOLD_AFTER   = 40;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned N_DIRECTED   = 28;

  typedef enum logic [1:0] {ROW_CHAR, ROW_END, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t      kind;
    b85dec_reg_t    reg_idx;
    logic [31:0]    value;
    logic           typed;
    b85dec_status_t status;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        in_mode = 1'b0;
  logic [7:0]  in_char_code = 8'h00;
  logic        pop = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'h0;
  logic [31:0] pwdata = 32'h0;
  logic        full;
  logic        empty;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic [2:0]  out_status;
  logic        out_last;
  logic [31:0] prdata;
  logic        pready;

  // decoder model state and register copies
  logic [31:0]    grp_word = '0;
  int unsigned    digit_cnt = 0;
  int unsigned    byte_cnt = 0;
  logic [7:0]     xor_acc = '0;
  logic [31:0]    sum_acc = '0;
  logic [31:0]    rot_acc = '0;
  logic           pad_bad = 1'b0;
  b85dec_status_t err_code = ST_OK;
  logic [24:0]    cfg_size = '0;
  logic [31:0]    cfg_xor = '0;
  logic [31:0]    cfg_sum = '0;
  logic [31:0]    cfg_rot = '0;

  b85dec_res_t decoded_q[$];
  int unsigned fail_count = 0;
  int unsigned burst_left = 0;

  logic [7:0] blanks [4] = '{CH_TAB, CH_LF, CH_CR, CH_SPACE};

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_END,  REG_DECL_SIZE, 32'h0000_00FF,   1'b1, ST_OK},
    '{ROW_CFG,  REG_DECL_SIZE, 32'h0100_0000,   1'b0, ST_OK},
    '{ROW_END,  REG_DECL_SIZE, 32'h0000_0000,   1'b1, ST_LENGTH},
    '{ROW_CFG,  REG_DECL_SIZE, 32'h00FF_FFFF,   1'b0, ST_OK},
    '{ROW_END,  REG_DECL_SIZE, 32'h0000_0080,   1'b1, ST_LENGTH},
    '{ROW_CFG,  REG_EXP_XOR,   32'hFFFF_FFFF,   1'b0, ST_OK},
    '{ROW_CFG,  REG_EXP_SUM,   32'hFFFF_FFFF,   1'b0, ST_OK},
    '{ROW_CFG,  REG_EXP_ROT,   32'hFFFF_FFFF,   1'b0, ST_OK},
    '{ROW_CFG,  REG_DECL_SIZE, 32'd64,          1'b0, ST_OK},
    '{ROW_CHAR, REG_DECL_SIZE, 32'(CH_LAST),    1'b0, ST_OK},
    '{ROW_CHAR, REG_DECL_SIZE, 32'(CH_LAST),    1'b0, ST_OK},
    '{ROW_CHAR, REG_DECL_SIZE, 32'(CH_SPACE),   1'b0, ST_OK},
    '{ROW_END,  REG_DECL_SIZE, 32'h0000_0000,   1'b1, ST_PARTIAL},
    '{ROW_CHAR, REG_DECL_SIZE, 32'(CH_LAST),    1'b0, ST_OK},
    '{ROW_CHAR, REG_DECL_SIZE, 32'(CH_TAB),     1'b0, ST_OK},
    '{ROW_CHAR, REG_DECL_SIZE, 32'(CH_LAST),    1'b0, ST_OK},
    '{ROW_CHAR, REG_DECL_SIZE, 32'(CH_LF),      1'b0, ST_OK},
    '{ROW_CHAR, REG_DECL_SIZE, 32'(CH_LAST),    1'b0, ST_OK},
    '{ROW_CHAR, REG_DECL_SIZE, 32'(CH_ZERO),    1'b0, ST_OK},
    '{ROW_CHAR, REG_DECL_SIZE, 32'(CH_CR),      1'b0, ST_OK},
    '{ROW_CHAR, REG_DECL_SIZE, 32'(CH_FIRST),   1'b0, ST_OK},
    '{ROW_CHAR, REG_DECL_SIZE, 32'(CH_FIRST),   1'b0, ST_OK},
    '{ROW_CHAR, REG_DECL_SIZE, 32'(CH_FIRST),   1'b0, ST_OK},
    '{ROW_CHAR, REG_DECL_SIZE, 32'(CH_FIRST),   1'b0, ST_OK},
    '{ROW_CHAR, REG_DECL_SIZE, 32'(CH_FIRST),   1'b0, ST_OK},
    '{ROW_END,  REG_DECL_SIZE, 32'h0000_0000,   1'b0, ST_OK},
    '{ROW_CFG,  REG_DECL_SIZE, 32'd12,          1'b0, ST_OK},
    '{ROW_END,  REG_DECL_SIZE, 32'h0000_0000,   1'b1, ST_CHECKSUM}
  };

  btoa_base85_decoder_top #(
    .MAX_OUTPUT_BYTES(MAX_BYTES)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_mode        (in_mode),
    .in_char_code   (in_char_code),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_status     (out_status),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_SPACE;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_FIRST && c <= CH_LAST;
  endfunction

  function automatic void note_fail(string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t: %s", $time, what);
    end
  endfunction

  // Four big-endian bytes into the checksums; bytes past the size are pad.
  function automatic void split_word(logic [31:0] w);
    b85dec_res_t got [4];
    int n;
    logic [7:0] b;
    n = 0;
    for (int i = 0; i < 4; i++) begin
      b = w[31 - 8 * i -: 8];
      xor_acc = xor_acc ^ b;
      sum_acc = sum_acc + 32'(b) + 32'd1;
      rot_acc = {rot_acc[30:0], rot_acc[31]} + 32'(b);
      if (byte_cnt < cfg_size) begin
        got[n] = '{data: b, byte_valid: 1'b1, status: ST_OK, last: 1'b0};
        n++;
      end else if (b != 8'h00) begin
        pad_bad = 1'b1;
      end
      byte_cnt++;
    end
    for (int k = 0; k < n; k++) begin
      if (k == n - 1) got[k].last = 1'b1;
      decoded_q.push_back(got[k]);
    end
  endfunction

  function automatic void decode_char(logic m, logic [7:0] c);
    b85dec_status_t st;
    logic [31:0] w;
    if (m) begin
      if (err_code != ST_OK) st = err_code;
      else if (digit_cnt != 0) st = ST_PARTIAL;
      else if (cfg_size > MAX_BYTES || cfg_size > byte_cnt || byte_cnt - cfg_size > PAD_MAX)
        st = ST_LENGTH;
      else if (pad_bad) st = ST_PAD;
      else if ({24'h0, xor_acc} != cfg_xor || sum_acc != cfg_sum || rot_acc != cfg_rot)
        st = ST_CHECKSUM;
      else st = ST_OK;
      decoded_q.push_back('{data: 8'h00, byte_valid: 1'b0, status: st, last: 1'b1});
    end else if (err_code != ST_OK || is_blank(c)) begin
    end else if (c == CH_ZERO) begin
      if (digit_cnt != 0) err_code = ST_Z_IN_GROUP;
      else if (byte_cnt >= MAX_BYTES) err_code = ST_OVERFLOW;
      else split_word(32'h0);
    end else if (!is_digit(c)) begin
      err_code = ST_BAD_CHAR;
    end else begin
      grp_word = grp_word * 32'(RADIX) + 32'(c - CH_FIRST);
      digit_cnt++;
      if (digit_cnt == GROUP_LEN) begin
        w = grp_word;
        grp_word = '0;
        digit_cnt = 0;
        if (byte_cnt >= MAX_BYTES) err_code = ST_OVERFLOW;
        else split_word(w);
      end
    end
  endfunction

  task automatic send_beat(logic m, logic [7:0] c);
    if (burst_left == 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end else begin
      @(negedge clk);
    end
    push <= 1'b1;
    in_mode <= m;
    in_char_code <= c;
    do @(posedge clk); while (full);
    decode_char(m, c);
    burst_left--;
  endtask

  task automatic send_digit();
    send_beat(1'b0, 8'($urandom_range(CH_FIRST, CH_LAST)));
  endtask

  task automatic drain_idle();
    @(negedge clk);
    push <= 1'b0;
    burst_left = 0;
    wait (decoded_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(b85dec_reg_t idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DECL_SIZE: cfg_size = v[24:0];
      REG_EXP_XOR:   cfg_xor = v;
      REG_EXP_SUM:   cfg_sum = v;
      REG_EXP_ROT:   cfg_rot = v;
      default:       ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : result_sink
    logic [15:0] stall_pat;
    int unsigned tick;
    int unsigned seen;
    bit held;
    b85dec_res_t got, want;
    stall_pat = '1;
    tick = 0;
    seen = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && seen >= HOLD_AFTER) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (tick % 16 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pat = 16'($urandom);
          1: stall_pat = 16'($urandom | $urandom);
          default: stall_pat = '1;
        endcase
      end
      pop <= stall_pat[tick % 16];
      tick++;
      @(posedge clk);
      if (pop && !empty) begin
        got.data = out_byte;
        got.byte_valid = out_byte_valid;
        got.status = b85dec_status_t'(out_status);
        got.last = out_last;
        seen++;
        if (decoded_q.size() == 0) begin
          note_fail($sformatf("unexpected beat: byte=%h valid=%b status=%0d last=%b",
                              got.data, got.byte_valid, got.status, got.last));
        end else begin
          want = decoded_q.pop_front();
          if (got !== want) begin
            note_fail($sformatf({"mismatch: expected byte=%h valid=%b status=%0d last=%b,",
                                 " got byte=%h valid=%b status=%0d last=%b"},
                                want.data, want.byte_valid, want.status, want.last,
                                got.data, got.byte_valid, got.status, got.last));
          end
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || (psel && penable && pwrite && pready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   row;
    int unsigned item_total;
    int unsigned phase_len;
    int unsigned sent;
    int unsigned run;
    int unsigned sel;
    int unsigned which;
    logic [31:0] flip;
    logic [7:0]  c;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        drain_idle();
        write_reg(row.reg_idx, row.value);
      end else begin
        send_beat(row.kind == ROW_END, row.value[7:0]);
        if (row.typed) begin
          // the table's status stands in for the modeled one
          void'(decoded_q.pop_back());
          decoded_q.push_back('{data: 8'h00, byte_valid: 1'b0, status: row.status,
                                last: 1'b1});
        end
      end
    end

    // random phases: mostly well-formed groups, some blanks, z runs and early ends
    item_total = 0;
    while (item_total < RANDOM_ITEMS) begin
      phase_len = $urandom_range(10, 40);
      drain_idle();
      write_reg(REG_DECL_SIZE, 32'(byte_cnt + 4 * (phase_len + 8) + $urandom_range(0, 3)));
      sent = 0;
      while (sent < phase_len) begin
        sel = $urandom_range(0, 99);
        if (sel < 6) begin
          send_beat(1'b1, 8'($urandom_range(0, 255)));
          sent++;
        end else if (sel < 18) begin
          send_beat(1'b0, blanks[$urandom_range(0, 3)]);
          sent++;
        end else if (sel < 28 && digit_cnt == 0) begin
          run = $urandom_range(1, 6);
          repeat (run) send_beat(1'b0, CH_ZERO);
          sent += run;
        end else begin
          send_digit();
          sent++;
        end
      end
      if ($urandom_range(0, 1) == 1) begin
        while (digit_cnt != 0) send_digit();
      end
      drain_idle();
      flip = 32'h0;
      if ($urandom_range(0, 3) == 0) flip = 32'h1 << $urandom_range(0, 31);
      which = $urandom_range(0, 2);
      write_reg(REG_EXP_XOR, {24'h0, xor_acc} ^ ((which == 0) ? flip : 32'h0));
      write_reg(REG_EXP_SUM, sum_acc ^ ((which == 1) ? flip : 32'h0));
      write_reg(REG_EXP_ROT, rot_acc ^ ((which == 2) ? flip : 32'h0));
      write_reg(REG_DECL_SIZE,
                32'(byte_cnt - $urandom_range(0, (byte_cnt < PAD_MAX) ? byte_cnt : PAD_MAX)));
      send_beat(1'b1, 8'($urandom_range(0, 255)));
      item_total += sent + 1;
    end

    // nonzero byte in the padding
    drain_idle();
    write_reg(REG_DECL_SIZE, 32'(byte_cnt + 8));
    while (digit_cnt != 0) send_beat(1'b0, CH_FIRST);
    drain_idle();
    write_reg(REG_DECL_SIZE, 32'(byte_cnt + PAD_MAX));
    repeat (4) send_beat(1'b0, CH_FIRST);
    send_beat(1'b0, CH_FIRST + 8'd1);
    send_beat(1'b1, 8'($urandom_range(0, 255)));

    // one sticky payload error, then traffic whose characters must be ignored
    case ($urandom_range(0, 2))
      0: begin
        repeat ($urandom_range(0, 4)) send_digit();
        do c = 8'($urandom_range(0, 255)); while (is_blank(c) || is_digit(c) || c == CH_ZERO);
        send_beat(1'b0, c);
      end
      1: begin
        repeat ($urandom_range(1, 4)) send_digit();
        send_beat(1'b0, CH_ZERO);
      end
      default: begin
        drain_idle();
        write_reg(REG_DECL_SIZE, 32'(byte_cnt));
        while (byte_cnt < MAX_BYTES) send_beat(1'b0, CH_ZERO);
        if ($urandom_range(0, 1) == 1) repeat (GROUP_LEN) send_digit();
        else send_beat(1'b0, CH_ZERO);
      end
    endcase
    repeat (12) send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    send_beat(1'b1, 8'($urandom_range(0, 255)));

    drain_idle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/b85dec_pkg.sv
rtl/b85dec_fifo.sv
rtl/b85dec_front.sv
rtl/b85dec_back.sv
rtl/btoa_base85_decoder_top.sv
tb/sv/tb_btoa_base85_decoder_top.sv
